FILE: src/tmn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmn_pkg
// Shared types and codes of the ticket mutex node: the request and response
// transfer formats, message kinds, operation codes and the job descriptor
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package tmn_pkg;

   localparam int MAX_PEERS_DEF   = 16;
   localparam int DEFER_DEPTH_DEF = 16;
   localparam int BCAST_CAP       = 16;

   // operation codes
   localparam logic [1:0] OP_REMOTE_REQ   = 2'd0;
   localparam logic [1:0] OP_REMOTE_REPLY = 2'd1;
   localparam logic [1:0] OP_LOCAL_REQ    = 2'd2;
   localparam logic [1:0] OP_LOCAL_REL    = 2'd3;

   // message kinds
   localparam logic [1:0] SEND_NONE    = 2'd0;
   localparam logic [1:0] SEND_REPLY   = 2'd1;
   localparam logic [1:0] SEND_REQUEST = 2'd2;
   localparam logic [1:0] SEND_NOTICE  = 2'd3;

   localparam logic signed [3:0] PRIO_NOTICE = -4'sd1;
   localparam logic signed [3:0] PRIO_READER = 4'sd5;
   localparam logic [2:0]        CLASS_READER = 3'd5;

   // configuration register indexes
   localparam int         CSR_IDX_W      = 1;
   localparam int         CSR_DATA_W     = 8;
   localparam logic [0:0] CSR_NODE_ID    = 1'b0;
   localparam logic [0:0] CSR_PEER_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0]        operation;
      logic [7:0]        peer_id;
      logic [15:0]       ticket_in;
      logic signed [3:0] priority_in;
      logic [4:0]        class_mask;
   } req_type;

   typedef struct packed {
      logic [1:0]        send_kind;
      logic [7:0]        dest_peer;
      logic [15:0]       ticket_out;
      logic signed [3:0] priority_out;
      logic              granted;
      logic [2:0]        granted_class;
      logic              read_enabled;
      logic              defer_overflow;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_ONE,
      JOB_GRANT,
      JOB_RUN
   } job_kind_type;

   // one unit of work for the back end
   typedef struct packed {
      job_kind_type      kind;
      logic [1:0]        send_kind;  // single item kind, or kind of the run
      logic [7:0]        dest;       // single item destination
      logic              ovf;        // single item overflow flag
      logic              from_mem;   // run destinations come from the defer store
      logic [4:0]        run_len;
      logic [15:0]       ticket;
      logic signed [3:0] prio;
      logic [2:0]        gclass;
      logic              rd_en;
   } job_type;

endpackage

FILE: src/tmn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/tmn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmn_front
// Front end: holds the protocol state and configuration, classifies each
// accepted operation, updates state and hands a job to the back end.
// ----------------------------------------------------------------------------
module tmn_front #(
   parameter int PEER_CAP  = 16,
   parameter int DEFER_CAP = 16,
   localparam int AW = (DEFER_CAP > 1) ? $clog2(DEFER_CAP) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  tmn_pkg::req_type                 req,
   input  logic                             csr_we,
   input  logic [tmn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tmn_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                             push,
   output tmn_pkg::job_type                 job,
   output logic                             ram_we,
   output logic [AW-1:0]                    ram_waddr,
   output logic [7:0]                       ram_wdata
);

   localparam logic [4:0] PeerCapW  = 5'(PEER_CAP);
   localparam logic [4:0] DeferCapW = 5'(DEFER_CAP);

   logic [7:0]  node_id_ff;
   logic [4:0]  peer_count_ff;
   logic [15:0] own_ticket_ff, own_ticket_in;
   logic [15:0] highest_seen_ff, highest_seen_in;
   logic        wanting_ff, wanting_in;
   logic        in_section_ff, in_section_in;
   logic [4:0]  reply_tally_ff, reply_tally_in;
   logic [2:0]  own_class_ff, own_class_in;
   logic [4:0]  deferred_total_ff, deferred_total_in;
   logic        reader_flag_ff, reader_flag_in;

   logic [4:0]  eff_peers;
   logic [2:0]  pick_class;
   logic        defer_wr;

   assign eff_peers = (peer_count_ff > PeerCapW) ? PeerCapW : peer_count_ff;

   // lowest set bit of the mask is the highest waiting class
   always_comb begin
      pick_class = 3'd0;
      for (int i = 4; i >= 0; i--) begin
         if (req.class_mask[i]) begin
            pick_class = 3'(i + 1);
         end
      end
   end

   always_comb begin
      own_ticket_in     = own_ticket_ff;
      highest_seen_in   = highest_seen_ff;
      wanting_in        = wanting_ff;
      in_section_in     = in_section_ff;
      reply_tally_in    = reply_tally_ff;
      own_class_in      = own_class_ff;
      deferred_total_in = deferred_total_ff;
      reader_flag_in    = reader_flag_ff;
      defer_wr          = 1'b0;
      job               = '0;
      job.kind          = tmn_pkg::JOB_ONE;
      job.send_kind     = tmn_pkg::SEND_NONE;

      unique case (req.operation)
         tmn_pkg::OP_REMOTE_REQ: begin
            if (req.priority_in == tmn_pkg::PRIO_NOTICE) begin
               reader_flag_in = 1'b1;
            end else begin
               if (req.ticket_in > highest_seen_ff) begin
                  highest_seen_in = req.ticket_in;
               end
               if (req.priority_in != tmn_pkg::PRIO_READER) begin
                  reader_flag_in = 1'b0;
               end
               if (!in_section_ff && (!wanting_ff || req.ticket_in < own_ticket_ff ||
                   (req.ticket_in == own_ticket_ff && req.peer_id < node_id_ff))) begin
                  job.send_kind = tmn_pkg::SEND_REPLY;
                  job.dest      = req.peer_id;
               end else if (deferred_total_ff < DeferCapW) begin
                  defer_wr          = 1'b1;
                  deferred_total_in = deferred_total_ff + 5'd1;
               end else begin
                  job.ovf = 1'b1;
               end
            end
         end
         tmn_pkg::OP_REMOTE_REPLY: begin
            if (wanting_ff && !in_section_ff) begin
               reply_tally_in = (reply_tally_ff == 5'd31) ? reply_tally_ff
                                                          : reply_tally_ff + 5'd1;
               if (reply_tally_in >= eff_peers) begin
                  in_section_in = 1'b1;
                  job.kind      = tmn_pkg::JOB_GRANT;
                  job.send_kind = tmn_pkg::SEND_NOTICE;
                  job.ticket    = own_ticket_ff;
                  job.prio      = tmn_pkg::PRIO_NOTICE;
                  if (own_class_ff == tmn_pkg::CLASS_READER) begin
                     reader_flag_in = 1'b1;
                     job.run_len    = eff_peers;
                  end
               end
            end
         end
         tmn_pkg::OP_LOCAL_REQ: begin
            if (!wanting_ff && !in_section_ff && req.class_mask != 5'd0) begin
               own_class_in = pick_class;
               if (pick_class != tmn_pkg::CLASS_READER) begin
                  reader_flag_in = 1'b0;
               end
               wanting_in     = 1'b1;
               own_ticket_in  = (highest_seen_ff == 16'hFFFF) ? highest_seen_ff
                                                              : highest_seen_ff + 16'd1;
               reply_tally_in = 5'd0;
               job.ticket     = own_ticket_in;
               if (eff_peers != 5'd0) begin
                  job.kind      = tmn_pkg::JOB_RUN;
                  job.send_kind = tmn_pkg::SEND_REQUEST;
                  job.run_len   = eff_peers;
                  job.prio      = signed'({1'b0, pick_class});
               end else begin
                  // no peers: grant at once, notice run is empty
                  in_section_in = 1'b1;
                  job.kind      = tmn_pkg::JOB_GRANT;
                  job.send_kind = tmn_pkg::SEND_NOTICE;
                  job.prio      = tmn_pkg::PRIO_NOTICE;
                  if (pick_class == tmn_pkg::CLASS_READER) begin
                     reader_flag_in = 1'b1;
                  end
               end
            end
         end
         tmn_pkg::OP_LOCAL_REL: begin
            if (in_section_ff) begin
               in_section_in     = 1'b0;
               wanting_in        = 1'b0;
               reader_flag_in    = 1'b0;
               deferred_total_in = 5'd0;
               job.kind          = tmn_pkg::JOB_RUN;
               job.send_kind     = tmn_pkg::SEND_REPLY;
               job.from_mem      = 1'b1;
               job.run_len       = deferred_total_ff;
            end
         end
         default: ;
      endcase

      job.gclass = own_class_in;
      job.rd_en  = reader_flag_in;
   end

   assign push      = accept;
   assign ram_we    = accept & defer_wr;
   assign ram_waddr = deferred_total_ff[AW-1:0];
   assign ram_wdata = req.peer_id;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff        <= '0;
         peer_count_ff     <= '0;
         own_ticket_ff     <= '0;
         highest_seen_ff   <= '0;
         wanting_ff        <= 1'b0;
         in_section_ff     <= 1'b0;
         reply_tally_ff    <= '0;
         own_class_ff      <= '0;
         deferred_total_ff <= '0;
         reader_flag_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               tmn_pkg::CSR_NODE_ID:    node_id_ff    <= csr_wdata;
               tmn_pkg::CSR_PEER_COUNT: peer_count_ff <= csr_wdata[4:0];
               default: ;
            endcase
         end
         if (accept) begin
            own_ticket_ff     <= own_ticket_in;
            highest_seen_ff   <= highest_seen_in;
            wanting_ff        <= wanting_in;
            in_section_ff     <= in_section_in;
            reply_tally_ff    <= reply_tally_in;
            own_class_ff      <= own_class_in;
            deferred_total_ff <= deferred_total_in;
            reader_flag_ff    <= reader_flag_in;
         end
      end
   end

endmodule

FILE: src/tmn_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmn_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tmn_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tmn_pkg::job_type push_job,
   input  logic             pop,
   output logic             empty,
   output tmn_pkg::job_type head_job
);

   tmn_pkg::job_type slot_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   logic do_push, do_pop;

   assign do_push  = push && (count_ff != 2'd2);
   assign do_pop   = pop && (count_ff != 2'd0);
   assign empty    = (count_ff == 2'd0);
   assign head_job = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

FILE: src/tmn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmn_back
// Back end: takes one job at a time from the queue and plays out its
// result items, one per cycle, reading deferred peers from the store.
// ----------------------------------------------------------------------------
module tmn_back #(
   parameter int DEFER_CAP = 16,
   localparam int AW = (DEFER_CAP > 1) ? $clog2(DEFER_CAP) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  tmn_pkg::job_type q_job,
   output logic             pop,
   output logic             active,
   output logic [AW-1:0]    ram_raddr,
   input  logic [7:0]       ram_rdata,
   output logic             rsp_valid,
   output tmn_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_RUN
   } state_type;

   state_type        state_ff;
   tmn_pkg::job_type job_ff;
   logic [4:0]       cnt_ff;
   logic [AW-1:0]    rd_idx_ff;
   logic             rsp_valid_ff;
   tmn_pkg::rsp_type rsp_data_ff;

   function automatic tmn_pkg::rsp_type make_item(
      input logic [1:0]        kind,
      input logic [7:0]        dest,
      input logic [15:0]       ticket,
      input logic signed [3:0] prio,
      input logic              grant,
      input logic              ovf,
      input tmn_pkg::job_type  j,
      input logic              last
   );
      tmn_pkg::rsp_type r;
      r.send_kind      = kind;
      r.dest_peer      = dest;
      r.ticket_out     = ticket;
      r.priority_out   = prio;
      r.granted        = grant;
      r.granted_class  = j.gclass;
      r.read_enabled   = j.rd_en;
      r.defer_overflow = ovf;
      r.last           = last;
      return r;
   endfunction

   assign pop       = (state_ff == ST_IDLE) && !q_empty;
   assign active    = (state_ff != ST_IDLE);
   assign ram_raddr = rd_idx_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         rd_idx_ff    <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  job_ff    <= q_job;
                  cnt_ff    <= '0;
                  rd_idx_ff <= '0;
                  unique case (q_job.kind)
                     tmn_pkg::JOB_ONE: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_data_ff  <= make_item(q_job.send_kind, q_job.dest, 16'd0,
                                                  4'sd0, 1'b0, q_job.ovf, q_job, 1'b1);
                     end
                     tmn_pkg::JOB_GRANT: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_data_ff  <= make_item(tmn_pkg::SEND_NONE, 8'd0, 16'd0, 4'sd0,
                                                  1'b1, 1'b0, q_job,
                                                  q_job.run_len == 5'd0);
                        if (q_job.run_len != 5'd0) begin
                           state_ff <= ST_RUN;
                        end
                     end
                     tmn_pkg::JOB_RUN: begin
                        if (q_job.run_len == 5'd0) begin
                           // release with nothing deferred
                           rsp_valid_ff <= 1'b1;
                           rsp_data_ff  <= make_item(tmn_pkg::SEND_NONE, 8'd0, 16'd0,
                                                     4'sd0, 1'b0, 1'b0, q_job, 1'b1);
                        end else if (q_job.from_mem) begin
                           state_ff <= ST_FILL;
                        end else begin
                           state_ff <= ST_RUN;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_FILL: begin
               // first store read is in flight
               rd_idx_ff <= rd_idx_ff + AW'(1);
               state_ff  <= ST_RUN;
            end
            ST_RUN: begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= make_item(job_ff.send_kind,
                                         job_ff.from_mem ? ram_rdata : 8'(cnt_ff),
                                         job_ff.ticket, job_ff.prio, 1'b0, 1'b0, job_ff,
                                         cnt_ff == job_ff.run_len - 5'd1);
               cnt_ff    <= cnt_ff + 5'd1;
               rd_idx_ff <= rd_idx_ff + AW'(1);
               if (cnt_ff == job_ff.run_len - 5'd1) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: src/ticket_mutex_node.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ticket_mutex_node
// One node of a ticket-based distributed mutual exclusion scheme with five
// local priority classes, deferred replies and reader notices.
// ----------------------------------------------------------------------------
// Usage: raise start with an operation on req_data; it is taken at the edge
// where start is high and busy is low, and busy then stays high until the
// last result of that operation has been presented. Results come on rsp_data
// for one cycle each under rsp_valid, back to back, with last set on the
// final one; the receiver has no way to hold them off and must take every
// one. A one-message operation shows its result once it has passed through
// the job queue and the back end's output register, and busy is already low
// in that cycle. A request broadcast to n peers starts once the back end has
// entered its run state and then sends one message per cycle; a reader grant
// sends its n read notices right behind the grant item. A release that
// answers m deferred peers first passes through a fill state for the first
// read of the deferred store. The back end has a single message port.
// Configuration (csr_we, csr_index, csr_wdata) is written at the edge where
// csr_we is high and must only change while busy is low and no result
// is pending. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module ticket_mutex_node #(
   parameter int MAX_PEERS   = tmn_pkg::MAX_PEERS_DEF,
   parameter int DEFER_DEPTH = tmn_pkg::DEFER_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  tmn_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output tmn_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [tmn_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tmn_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Broadcasts and the deferred store never exceed sixteen entries.
   localparam int PeerCap  = (MAX_PEERS < tmn_pkg::BCAST_CAP) ? MAX_PEERS
                                                              : tmn_pkg::BCAST_CAP;
   localparam int DeferCap = (DEFER_DEPTH < tmn_pkg::BCAST_CAP) ? DEFER_DEPTH
                                                                : tmn_pkg::BCAST_CAP;
   localparam int AW       = (DeferCap > 1) ? $clog2(DeferCap) : 1;

   logic             accept;
   logic             push;
   tmn_pkg::job_type push_job;
   logic             pop;
   logic             q_empty;
   tmn_pkg::job_type head_job;
   logic             back_active;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [7:0]       ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [7:0]       ram_rdata;

   // An operation is in flight from its transfer until the back end has
   // presented its last result.
   assign busy   = reset | ~q_empty | back_active;
   assign accept = start & ~busy;

   tmn_front #(
      .PEER_CAP  (PeerCap),
      .DEFER_CAP (DeferCap)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push),
      .job       (push_job),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata)
   );

   tmn_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .empty    (q_empty),
      .head_job (head_job)
   );

   // deferred peer ids, written by the front end, drained on release
   tmn_ram #(
      .WIDTH (8),
      .DEPTH (DeferCap)
   ) u_defer_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   tmn_back #(
      .DEFER_CAP (DeferCap)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (head_job),
      .pop       (pop),
      .active    (back_active),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/tmn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmn_checker
// Port-level checks of the ticket mutex node, bound to the top level.
// ----------------------------------------------------------------------------
module tmn_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input tmn_pkg::req_type                req_data,
   input logic                            rsp_valid,
   input tmn_pkg::rsp_type                rsp_data,
   input logic                            csr_we,
   input logic [tmn_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [tmn_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // an accepted operation always holds busy in the next cycle
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy low right after a transfer");

   // results of one operation come without gaps until last
   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> rsp_valid)
      else $error("gap inside a result burst");

   // the grant item carries no message
   a_grant_no_message: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.granted |-> rsp_data.send_kind == tmn_pkg::SEND_NONE)
      else $error("grant item carries a message");

   // own tickets start at one, so a request never carries ticket zero
   a_request_ticket: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.send_kind == tmn_pkg::SEND_REQUEST
         |-> rsp_data.ticket_out != 16'd0)
      else $error("request with ticket zero");

   // a dropped deferral is the only result of its operation
   a_overflow_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.defer_overflow |-> rsp_data.last)
      else $error("overflow flag on a non-final item");

endmodule

bind ticket_mutex_node tmn_checker u_checker (.*);
